### hdl/wkb_pkg.sv
// Shared types, constants and saturation helpers for the waypoint kinematics block.
package wkb_pkg;

  // Coordinate format: signed fixed point, CW bits total, FB fraction bits.
  localparam int CW   = 32;
  localparam int FB   = 16;
  // The time step field is always a 32-bit unsigned value.
  localparam int TW   = 32;
  // Magnitude of a coordinate difference; also the multiplier operand width.
  localparam int DW   = CW + 1;
  // Full product width and radicand width.
  localparam int PW   = 2 * DW;
  // Partial remainder width of the root/divide unit.
  localparam int RW   = DW + 3;
  // Width of one per-axis move amount, up to twice the coordinate span.
  localparam int MW   = CW + 2;
  // Iteration counter width of the root/divide unit.
  localparam int CNTW = $clog2(DW + 1);
  // Number of axes.
  localparam int NAX  = 3;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    CMD_ADVANCE = 3'd0,
    CMD_SET_POS = 3'd1,
    CMD_SET_VEL = 3'd2,
    CMD_SET_WPT = 3'd3,
    CMD_CLR_WPT = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_Z_MIN  = 3'd4,
    REG_Z_MAX  = 3'd5,
    REG_BND_EN = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CMD,
    S_SQ,
    S_RT,
    S_RTW,
    S_RMUL,
    S_RCHK,
    S_WMUL,
    S_WDIV,
    S_WDW,
    S_LMUL,
    S_LUPD,
    S_CLAMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } wkb_it_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wkb_it_stat_t;

  // Position plus or minus a move amount, saturated to the coordinate range.
  function automatic coord_t sat_move(input coord_t p, input logic [MW-1:0] m,
                                      input logic neg);
    logic signed [MW:0] ext;
    logic signed [MW:0] mx;
    logic signed [MW:0] s;
    coord_t             r;
    ext = {{(MW + 1 - CW){p[CW-1]}}, p};
    mx  = signed'({1'b0, m});
    s   = neg ? (ext - mx) : (ext + mx);
    if (s[MW:CW-1] == '0 || s[MW:CW-1] == '1) begin
      r = s[CW-1:0];
    end else if (s[MW]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // Negation that maps the most negative value to the largest one.
  function automatic coord_t neg_sat(input coord_t v);
    coord_t r;
    if (v == {1'b1, {(CW-1){1'b0}}}) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

### hdl/wkb_iter_unit.sv
// Shared bit-serial square root and division unit, one result bit per cycle.
module wkb_iter_unit import wkb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  wkb_it_ctrl_t    ctrl,
  input  logic [PW-1:0]   num,
  input  logic [DW-1:0]   den,
  output wkb_it_stat_t    stat,
  output logic [DW-1:0]   result
);

  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic            sqrt_r;
  logic [RW-1:0]   rem_r;
  logic [PW-1:0]   sh_r;
  logic [DW-1:0]   acc_r;
  logic [DW-1:0]   den_r;

  logic [RW-1:0]   rem2;
  logic [RW-1:0]   trial;
  logic            ge;
  logic [RW-1:0]   rem_nxt;
  logic [DW-1:0]   acc_nxt;
  logic [PW-1:0]   sh_nxt;

  // Square root takes two radicand bits per step, division one numerator bit.
  always_comb begin
    if (sqrt_r) begin
      rem2   = {rem_r[RW-3:0], sh_r[PW-1:PW-2]};
      trial  = {1'b0, acc_r, 2'b01};
      sh_nxt = {sh_r[PW-3:0], 2'b00};
    end else begin
      rem2   = {rem_r[RW-2:0], sh_r[PW-1]};
      trial  = {{(RW-DW){1'b0}}, den_r};
      sh_nxt = {sh_r[PW-2:0], 1'b0};
    end
    ge      = (rem2 >= trial);
    rem_nxt = ge ? (rem2 - trial) : rem2;
    acc_nxt = {acc_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNTW'(1));
      if (ctrl.start) begin
        cnt_r <= CNTW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  // The divide numerator is known to be below den * 2^DW, so its top half
  // seeds the remainder directly.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sqrt_r <= ctrl.is_sqrt;
      den_r  <= den;
      acc_r  <= '0;
      if (ctrl.is_sqrt) begin
        rem_r <= '0;
        sh_r  <= num;
      end else begin
        rem_r <= {{(RW-DW){1'b0}}, num[PW-1:DW]};
        sh_r  <= {num[DW-1:0], {DW{1'b0}}};
      end
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

### hdl/waypoint_kinematics_bounce.sv
// Top level of the waypoint kinematics block with a reflecting bounding box.
// One command is taken per input transfer and answered by exactly one output
// transfer carrying the position, velocity and waypoint flags after the
// command. A straight line advance makes one multiplier pass per axis. An
// advance toward a pending waypoint computes two vector lengths, distance
// and speed, each by three squaring passes on the shared 33x33 multiplier
// and a bit-serial square root; unless either is zero, one multiply for the
// reach follows and, if the waypoint is not reached, per axis a multiply
// and a division, all roots and divisions on the same root/divide unit.
// The input side is not ready while a command is in work; a finished
// result sits in the output register, so the next command can be taken
// while that result still waits for its transfer. Bounds are to be written
// through the configuration port only while the block is idle (the block
// itself does not enforce this) and apply from the next command that clamps.
module waypoint_kinematics_bounce import wkb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  // Command input.
  input  logic           in_tvalid,
  output logic           in_tready,
  // in_tdata, lowest bit up: value_x[31:0], value_y[31:0], value_z[31:0],
  // time_step[31:0].
  input  logic [127:0]   in_tdata,
  // in_tuser: command[2:0].
  input  logic [2:0]     in_tuser,
  // Result output.
  output logic           out_tvalid,
  input  logic           out_tready,
  // out_tdata, lowest bit up: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // 32 bits each.
  output logic [191:0]   out_tdata,
  // out_tuser, lowest bit up: waypoint_active, arrived.
  output logic [1:0]     out_tuser,
  // Configuration writes.
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  state_t        state_r, state_nxt;

  // Captured command.
  cmd_t          cmd_r;
  coord_t        val_r [NAX];
  logic [TW-1:0] dt_r;

  // Kinematic state.
  coord_t        pos_r [NAX];
  coord_t        vel_r [NAX];
  coord_t        tgt_r [NAX];
  logic          pend_r;
  logic          hit_r;

  // Bounds.
  coord_t        lo_r  [NAX];
  coord_t        hi_r  [NAX];
  logic          bnd_en_r;

  // Sequencer working registers.
  logic [1:0]    k_r;
  logic [1:0]    ax_r;
  logic          vsel_r;
  logic [PW-1:0] sum_r;
  logic [PW-1:0] prod_r;
  logic [DW-1:0] dist_r;
  logic [DW-1:0] speed_r;
  logic [DW-1:0] reach_r;

  // Result register.
  logic          out_valid_r;
  logic [191:0]  out_data_r;
  logic [1:0]    out_user_r;

  // Shared multiplier and root/divide unit.
  logic [DW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod_nxt;
  wkb_it_ctrl_t  it_ctrl;
  wkb_it_stat_t  it_stat;
  logic [PW-1:0] it_num;
  logic [DW-1:0] it_res;

  // Derived per-axis values.
  logic signed [DW-1:0] diff [NAX];
  logic [DW-1:0]        dmag [NAX];
  logic [DW-1:0]        vmag [NAX];
  logic [DW-1:0]        sq_op;
  logic [PW-FB-1:0]     scaled;
  logic [MW-1:0]        line_m;
  logic                 in_xfer, out_xfer, load_out;

  localparam logic [PW-FB-1:0] STEP_LIM = (PW-FB)'(1) << (CW + 1);

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      diff[i] = {tgt_r[i][CW-1], tgt_r[i]} - {pos_r[i][CW-1], pos_r[i]};
      dmag[i] = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
      vmag[i] = {1'b0, (vel_r[i][CW-1] ? (~vel_r[i] + coord_t'(1)) : vel_r[i])};
    end
  end

  always_comb begin
    if (k_r == 2'd3) begin
      sq_op = '0;
    end else if (vsel_r) begin
      sq_op = vmag[k_r];
    end else begin
      sq_op = dmag[k_r];
    end
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);
  assign scaled   = prod_r[PW-1:FB];
  assign line_m   = (scaled > STEP_LIM) ? STEP_LIM[MW-1:0] : scaled[MW-1:0];

  wkb_iter_unit u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (it_ctrl),
    .num    (it_num),
    .den    (dist_r),
    .stat   (it_stat),
    .result (it_res)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_CMD;
      S_CMD: begin
        case (cmd_r)
          CMD_ADVANCE: begin
            if (dt_r == '0) begin
              state_nxt = S_DONE;
            end else if (pend_r) begin
              state_nxt = S_SQ;
            end else begin
              state_nxt = S_LMUL;
            end
          end
          CMD_SET_POS: state_nxt = S_CLAMP;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_SQ:    if (k_r == 2'd3) state_nxt = S_RT;
      S_RT:    state_nxt = S_RTW;
      S_RTW: begin
        if (it_stat.done) begin
          if (!vsel_r) begin
            state_nxt = S_SQ;
          end else if (dist_r == '0 || it_res == '0) begin
            state_nxt = S_CLAMP;
          end else begin
            state_nxt = S_RMUL;
          end
        end
      end
      S_RMUL:  state_nxt = S_RCHK;
      S_RCHK: begin
        if ({{(PW-FB-DW){1'b0}}, dist_r} <= scaled) begin
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_WMUL;
        end
      end
      S_WMUL:  state_nxt = S_WDIV;
      S_WDIV:  state_nxt = S_WDW;
      S_WDW: begin
        if (it_stat.done) begin
          state_nxt = (ax_r == 2'd2) ? S_CLAMP : S_WMUL;
        end
      end
      S_LMUL:  state_nxt = S_LUPD;
      S_LUPD:  state_nxt = (ax_r == 2'd2) ? S_CLAMP : S_LMUL;
      S_CLAMP: state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output decode: handshake, multiplier operands and root/divide control.
  always_comb begin
    in_tready       = (state_r == S_IDLE);
    mul_a           = '0;
    mul_b           = '0;
    it_ctrl.start   = 1'b0;
    it_ctrl.is_sqrt = 1'b0;
    it_num          = prod_r;
    case (state_r)
      S_SQ: begin
        mul_a = sq_op;
        mul_b = sq_op;
      end
      S_RT: begin
        it_ctrl.start   = 1'b1;
        it_ctrl.is_sqrt = 1'b1;
        it_num          = sum_r;
      end
      S_RMUL: begin
        mul_a = speed_r;
        mul_b = DW'(dt_r);
      end
      S_WMUL: begin
        mul_a = dmag[ax_r];
        mul_b = reach_r;
      end
      S_WDIV: begin
        it_ctrl.start = 1'b1;
      end
      S_LMUL: begin
        mul_a = vmag[ax_r];
        mul_b = DW'(dt_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
      bnd_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_X_MIN:  lo_r[0]  <= coord_t'(cfg_data);
        REG_X_MAX:  hi_r[0]  <= coord_t'(cfg_data);
        REG_Y_MIN:  lo_r[1]  <= coord_t'(cfg_data);
        REG_Y_MAX:  hi_r[1]  <= coord_t'(cfg_data);
        REG_Z_MIN:  lo_r[2]  <= coord_t'(cfg_data);
        REG_Z_MAX:  hi_r[2]  <= coord_t'(cfg_data);
        REG_BND_EN: bnd_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command capture and working registers of the sequencer.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_xfer) begin
      cmd_r    <= cmd_t'(in_tuser);
      val_r[0] <= coord_t'(in_tdata[31:0]);
      val_r[1] <= coord_t'(in_tdata[63:32]);
      val_r[2] <= coord_t'(in_tdata[95:64]);
      dt_r     <= in_tdata[127:96];
    end
    case (state_r)
      S_CMD: begin
        k_r    <= '0;
        ax_r   <= '0;
        vsel_r <= 1'b0;
      end
      S_SQ: begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd0) begin
          sum_r <= '0;
        end else begin
          sum_r <= sum_r + prod_r;
        end
      end
      S_RTW: begin
        if (it_stat.done) begin
          k_r <= '0;
          if (!vsel_r) begin
            dist_r <= it_res;
            vsel_r <= 1'b1;
          end else begin
            speed_r <= it_res;
          end
        end
      end
      S_RCHK:  reach_r <= scaled[DW-1:0];
      S_WDW:   if (it_stat.done) ax_r <= ax_r + 2'd1;
      S_LUPD:  ax_r <= ax_r + 2'd1;
      default: ;
    endcase
  end

  // Kinematic state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        tgt_r[i] <= '0;
      end
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      case (state_r)
        S_CMD: begin
          hit_r <= 1'b0;
          case (cmd_r)
            CMD_SET_POS: for (int i = 0; i < NAX; i++) pos_r[i] <= val_r[i];
            CMD_SET_VEL: for (int i = 0; i < NAX; i++) vel_r[i] <= val_r[i];
            CMD_SET_WPT: begin
              for (int i = 0; i < NAX; i++) tgt_r[i] <= val_r[i];
              pend_r <= 1'b1;
            end
            CMD_CLR_WPT: pend_r <= 1'b0;
            default: ;
          endcase
        end
        S_RCHK: begin
          // The waypoint lies within this step's reach: snap onto it.
          if ({{(PW-FB-DW){1'b0}}, dist_r} <= scaled) begin
            for (int i = 0; i < NAX; i++) begin
              pos_r[i] <= tgt_r[i];
              vel_r[i] <= '0;
            end
            pend_r <= 1'b0;
            hit_r  <= 1'b1;
          end
        end
        S_WDW: begin
          if (it_stat.done) begin
            pos_r[ax_r] <= sat_move(pos_r[ax_r], MW'(it_res), diff[ax_r][DW-1]);
          end
        end
        S_LUPD: pos_r[ax_r] <= sat_move(pos_r[ax_r], line_m, vel_r[ax_r][CW-1]);
        S_CLAMP: begin
          if (bnd_en_r) begin
            for (int i = 0; i < NAX; i++) begin
              if (pos_r[i] < lo_r[i] || pos_r[i] > hi_r[i]) begin
                vel_r[i] <= neg_sat(vel_r[i]);
                // An inverted box ends on the maximum.
                if (lo_r[i] > hi_r[i] || pos_r[i] > hi_r[i]) begin
                  pos_r[i] <= hi_r[i];
                end else begin
                  pos_r[i] <= lo_r[i];
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};
      out_user_r <= {hit_r, pend_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Reaching the waypoint always clears it.
  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[0]))
    else $error("arrived reported with waypoint still active");

  // The root/divide unit is never restarted while it iterates.
  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    it_ctrl.start |-> !it_stat.busy)
    else $error("root/divide unit started while busy");

  // An accepted command is decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CMD))
    else $error("accepted command not decoded");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load_out)
    else $error("pending result overwritten");

endmodule

### verif/tb_waypoint_kinematics_bounce.sv
// Self-checking testbench for the waypoint kinematics block with a reflecting bounding box.
module tb_waypoint_kinematics_bounce import wkb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Slowest correct run: about 1500 commands, many of them waypoint advances,
  // with idle gaps and output stalls on top. The limit below is well above
  // that.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // A bound on the longest command in work, used as the settle time before
  // register writes and at the end of the run.
  localparam int          SETTLE_CYCLES = 250;
  localparam longint      COORD_MAX = 64'sd2147483647;
  localparam longint      COORD_MIN = -64'sd2147483648;
  localparam longint      STEP_CAP = 64'sd8589934592;
  localparam int          RANDOM_BLOCKS = 8;
  localparam int          ITEMS_PER_BLOCK = 185;

  // Expected result: status flags over the six packed coordinates, in the
  // same layout as {out_tuser, out_tdata}.
  typedef logic [193:0] status_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Shadow of the block: kinematic state and bounds registers.
  longint       mdl_pos[3];
  longint       mdl_vel[3];
  longint       mdl_tgt[3];
  bit           mdl_wpt_pending;
  longint       box_lo[3];
  longint       box_hi[3];
  bit           box_enable;

  status_word_t pending_status[$];
  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  status_count = 0;
  int unsigned  arrival_count = 0;
  int unsigned  bounce_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  waypoint_kinematics_bounce dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_status.size());
      $display("waypoint_kinematics_bounce regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random; the percentage changes per phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint clip_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Floor of the Euclidean length of a three-axis vector.
  function automatic logic [63:0] vector_length(input longint a, input longint b,
                                                input longint c);
    logic [127:0] sum;
    logic [127:0] trial;
    logic [63:0]  root;
    sum = 128'(magnitude(a)) * 128'(magnitude(a))
        + 128'(magnitude(b)) * 128'(magnitude(b))
        + 128'(magnitude(c)) * 128'(magnitude(c));
    root = '0;
    for (int b_idx = 63; b_idx >= 0; b_idx--) begin
      trial = 128'(root | (64'd1 << b_idx));
      if (trial * trial <= sum) root = trial[63:0];
    end
    return root;
  endfunction

  // Clamp each axis into the box and reflect its velocity.
  function automatic void reflect_at_bounds();
    longint p;
    if (!box_enable) return;
    for (int i = 0; i < 3; i++) begin
      p = mdl_pos[i];
      if (p < box_lo[i] || p > box_hi[i]) begin
        mdl_vel[i] = clip_coord(-mdl_vel[i]);
        if (p < box_lo[i]) p = box_lo[i];
        // An inverted box ends on its maximum.
        if (p > box_hi[i]) p = box_hi[i];
        mdl_pos[i] = clip_coord(p);
        bounce_count++;
      end
    end
  endfunction

  // One time step; returns 1 when the waypoint was reached.
  function automatic bit advance_state(input logic [31:0] step);
    longint       delta[3];
    logic [63:0]  distance;
    logic [63:0]  speed;
    logic [127:0] reach;
    logic [127:0] travel;
    longint       move;
    bit           reached;
    reached = 1'b0;
    if (step == 0) return 1'b0;
    if (mdl_wpt_pending) begin
      for (int i = 0; i < 3; i++) delta[i] = mdl_tgt[i] - mdl_pos[i];
      distance = vector_length(delta[0], delta[1], delta[2]);
      speed    = vector_length(mdl_vel[0], mdl_vel[1], mdl_vel[2]);
      // Standing on the waypoint or standing still: no move, waypoint kept.
      if (distance != 0 && speed != 0) begin
        reach = (128'(speed) * 128'(step)) >> FB;
        if (128'(distance) <= reach) begin
          for (int i = 0; i < 3; i++) begin
            mdl_pos[i] = mdl_tgt[i];
            mdl_vel[i] = 0;
          end
          mdl_wpt_pending = 1'b0;
          reached = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            travel = (128'(magnitude(delta[i])) * 128'(reach[63:0])) / 128'(distance);
            move = longint'(travel[63:0]);
            mdl_pos[i] = clip_coord(delta[i] < 0 ? mdl_pos[i] - move : mdl_pos[i] + move);
          end
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        travel = (128'(magnitude(mdl_vel[i])) * 128'(step)) >> FB;
        move = (travel > 128'(STEP_CAP)) ? STEP_CAP : longint'(travel[63:0]);
        mdl_pos[i] = clip_coord(mdl_vel[i] < 0 ? mdl_pos[i] - move : mdl_pos[i] + move);
      end
    end
    reflect_at_bounds();
    return reached;
  endfunction

  // Applies one command to the shadow state and returns the status it reports.
  function automatic status_word_t predict_status(input logic [2:0] cmd,
                                                  input logic [127:0] operands);
    longint       val[3];
    bit           reached;
    status_word_t word;
    reached = 1'b0;
    for (int i = 0; i < 3; i++) val[i] = longint'(signed'(operands[32*i +: 32]));
    case (cmd)
      CMD_ADVANCE: reached = advance_state(operands[127:96]);
      CMD_SET_POS: begin
        for (int i = 0; i < 3; i++) mdl_pos[i] = val[i];
        reflect_at_bounds();
      end
      CMD_SET_VEL: for (int i = 0; i < 3; i++) mdl_vel[i] = val[i];
      CMD_SET_WPT: begin
        for (int i = 0; i < 3; i++) mdl_tgt[i] = val[i];
        mdl_wpt_pending = 1'b1;
      end
      CMD_CLR_WPT: mdl_wpt_pending = 1'b0;
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      word[32*i +: 32]       = mdl_pos[i][31:0];
      word[32*(i + 3) +: 32] = mdl_vel[i][31:0];
    end
    word[192] = mdl_wpt_pending;
    word[193] = reached;
    if (reached) arrival_count++;
    return word;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every output transfer is compared with the oldest
  // expected status, one field at a time.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    status_word_t exp_word;
    status_word_t got_word;
    string        field_name[8];
    logic [31:0]  exp_field;
    logic [31:0]  got_field;
    field_name = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                   "waypoint_active", "arrived"};
    if (rst_n && out_tvalid && out_tready) begin
      status_count++;
      got_word = {out_tuser, out_tdata};
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer at cycle %0d: %h", cycle_count, got_word);
      end else begin
        exp_word = pending_status.pop_front();
        for (int f = 0; f < 8; f++) begin
          exp_field = (f < 6) ? exp_word[32*f +: 32] : 32'(exp_word[186 + f]);
          got_field = (f < 6) ? got_word[32*f +: 32] : 32'(got_word[186 + f]);
          if (exp_field !== got_field) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d field %s: expected %h, got %h", status_count,
                       field_name[f], exp_field, got_field);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Sends one command; the valid stays high into the next command unless
  // the sender decides to idle first.
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] vz,
                              input logic [31:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {step, vz, vy, vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(predict_status(cmd, {step, vz, vy, vx}));
    @(negedge clk);
  endtask

  // Waits until every result has been seen and the block has gone quiet.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_MIN:  box_lo[0] = longint'(signed'(data));
      REG_X_MAX:  box_hi[0] = longint'(signed'(data));
      REG_Y_MIN:  box_lo[1] = longint'(signed'(data));
      REG_Y_MAX:  box_hi[1] = longint'(signed'(data));
      REG_Z_MIN:  box_lo[2] = longint'(signed'(data));
      REG_Z_MAX:  box_hi[2] = longint'(signed'(data));
      REG_BND_EN: box_enable = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Loads a whole box; enable carries random upper bits that must be ignored.
  task automatic load_box(input logic [31:0] xl, input logic [31:0] xh,
                          input logic [31:0] yl, input logic [31:0] yh,
                          input logic [31:0] zl, input logic [31:0] zh, input bit en);
    drain_results();
    write_register(REG_X_MIN, xl);
    write_register(REG_X_MAX, xh);
    write_register(REG_Y_MIN, yl);
    write_register(REG_Y_MAX, yh);
    write_register(REG_Z_MIN, zl);
    write_register(REG_Z_MAX, zh);
    write_register(REG_BND_EN, {31'($urandom_range(32'h7fff_ffff)), en});
  endtask

  // Coordinates: mostly within some tens of meters, sometimes anywhere.
  function automatic logic [31:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($signed($urandom_range(32'h0028_0000)) - 32'sh0014_0000);
    if (sel < 75) return 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    if (sel < 92) return $urandom;
    if (sel < 96) return 32'h7fff_ffff;
    return 32'h8000_0000;
  endfunction

  // Velocities stay modest most of the time so waypoints take several steps.
  function automatic logic [31:0] pick_velocity();
    if ($urandom_range(99) < 75)
      return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
    return pick_coord();
  endfunction

  function automatic logic [31:0] pick_step();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(32'h0000_4000, 1);
    if (sel < 80) return $urandom_range(32'h0004_0000);
    if (sel < 88) return $urandom;
    if (sel < 94) return 32'd0;
    return 32'hffff_ffff;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_reset_and_bounds_registers();
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // A write past the last register must change nothing.
    write_register(3'(REG_BND_EN) + 3'd1, 32'hffff_ffff);
  endtask

  task automatic test_directed_commands();
    // Field extremes and a saturating straight line advance.
    send_command(CMD_SET_POS, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, '0);
    send_command(CMD_SET_VEL, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'hffff_ffff);
    // Zero step does nothing.
    send_command(CMD_ADVANCE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
    send_command(CMD_SET_POS, '0, '0, '0, 32'hffff_ffff);
    // Waypoint reached in one step, with velocity cleared.
    send_command(CMD_SET_VEL, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, '0);
    send_command(CMD_SET_WPT, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0001_0000);
    // Waypoint approached over two steps, then cleared.
    send_command(CMD_SET_VEL, 32'h0003_0000, '0, 32'hfffc_0000, '0);
    send_command(CMD_SET_WPT, 32'h0064_0000, 32'hff9c_0000, 32'h0032_0000, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0000_8000);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0002_0000);
    send_command(CMD_CLR_WPT, '0, '0, '0, '0);
    // Waypoint on the current position, and a pending waypoint at zero speed.
    send_command(CMD_SET_WPT, '0, '0, '0, '0);
    send_command(CMD_SET_POS, '0, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0001_0000);
    send_command(CMD_SET_VEL, '0, '0, '0, '0);
    send_command(CMD_SET_WPT, 32'h0010_0000, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0001_0000);
    // Codes past the last command report the state unchanged.
    send_command(3'd5, 32'h1234_5678, '0, '0, '0);
    send_command(3'd6, '0, '0, '0, '0);
    send_command(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // Bounce off a normal box with the most negative velocity on one axis,
    // then off an inverted box.
    load_box(32'hfff6_0000, 32'h000a_0000, 32'hfff6_0000, 32'h000a_0000,
             32'hfff6_0000, 32'h000a_0000, 1'b1);
    send_command(CMD_CLR_WPT, '0, '0, '0, '0);
    send_command(CMD_SET_VEL, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000, '0);
    send_command(CMD_ADVANCE, '0, '0, '0, 32'h0000_0100);
    send_command(CMD_SET_POS, 32'h0014_0000, 32'hffec_0000, '0, '0);
    load_box(32'h000a_0000, 32'hfff6_0000, 32'h0005_0000, 32'h0001_0000,
             32'h0000_0000, 32'h0000_0000, 1'b1);
    send_command(CMD_SET_POS, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, '0);
  endtask

  // Random commands, mostly advances, the rest setting position, velocity or
  // waypoint, clearing the waypoint or using codes past the last command.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned sel;
    logic [2:0]  cmd;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
      sel = $urandom_range(99);
      if (sel < 55)      cmd = CMD_ADVANCE;
      else if (sel < 65) cmd = CMD_SET_POS;
      else if (sel < 77) cmd = CMD_SET_VEL;
      else if (sel < 90) cmd = CMD_SET_WPT;
      else if (sel < 96) cmd = CMD_CLR_WPT;
      else               cmd = 3'($urandom_range(7, 5));
      if (cmd == CMD_SET_VEL)
        send_command(cmd, pick_velocity(), pick_velocity(), pick_velocity(), $urandom);
      else if (cmd == CMD_ADVANCE)
        send_command(cmd, $urandom, $urandom, $urandom, pick_step());
      else
        send_command(cmd, pick_coord(), pick_coord(), pick_coord(), $urandom);
    end
  endtask

  // Each idling phase runs under two different box settings: off and normal,
  // or full range and inverted.
  task automatic test_random_phases();
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan  = '{0, 76, 0, 25};
    stall_plan = '{0, 0, 76, 25};
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk % 4)
        0: load_box('0, '0, '0, '0, '0, '0, 1'b0);
        1: load_box(32'hffe2_0000, 32'h001e_0000, 32'hffec_0000, 32'h0014_0000,
                    32'hfff6_0000, 32'h0028_0000, 1'b1);
        2: load_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 1'b1);
        default: load_box($urandom, $urandom, pick_coord(), pick_coord(),
                          32'h0005_0000, 32'hfffb_0000, 1'b1);
      endcase
      test_random_traffic(idle_plan[blk / 2], stall_plan[blk / 2]);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      mdl_pos[i] = 0;
      mdl_vel[i] = 0;
      mdl_tgt[i] = 0;
      box_lo[i]  = 0;
      box_hi[i]  = 0;
    end
    mdl_wpt_pending = 1'b0;
    box_enable      = 1'b0;
    @(negedge clk);
    test_reset_and_bounds_registers();
    test_directed_commands();
    test_random_phases();
    drain_results();
    $display("covered %0d results, %0d waypoint arrivals, %0d axis bounces", status_count,
             arrival_count, bounce_count);
    $display("idle phases: none, sender, receiver, both; boxes off, normal, full, inverted");
    if (mismatch_count == 0) begin
      $display("waypoint_kinematics_bounce regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("waypoint_kinematics_bounce regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/wkb_pkg.sv
hdl/wkb_iter_unit.sv
hdl/waypoint_kinematics_bounce.sv
verif/tb_waypoint_kinematics_bounce.sv
